/* design/sha_pkg.sv */
`timescale 1ns / 1ps
package sha_pkg;

	typedef enum logic [1:0] {
		CMD_APPEND  = 2'd0,
		CMD_FINISH  = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_REJECTED = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [60:0] MAX_LEN = {61{1'b1}};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	// datapath commands
	typedef struct packed {
		logic       init;      // restore initial hash, clear length
		logic       wr_byte;   // write byte to block buffer
		logic [5:0] wr_addr;
		logic [7:0] wr_data;
		logic       len_inc;
		logic       blk_load;  // load round words from buffer, copy chain
		logic       round;     // one compression round
		logic [5:0] round_idx;
		logic       chain_add; // fold working vars into chain
		logic [2:0] rd_word;   // chain word for output
	} dp_cmd_t;

	typedef struct packed {
		logic        len_max;
		logic [60:0] length;
		logic [31:0] chain_word;
	} dp_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* design/sha_datapath.sv */
`timescale 1ns / 1ps
module sha_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  sha_pkg::dp_cmd_t   cmd,
	output sha_pkg::dp_stat_t  stat
);

	logic [31:0] blk_mem [16];
	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [60:0] len_q;

	// block buffer, held as big-endian words, one byte lane written per cycle while wr_byte is set
	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			case (cmd.wr_addr[1:0])
				2'd0:    blk_mem[cmd.wr_addr[5:2]][31:24] <= cmd.wr_data;
				2'd1:    blk_mem[cmd.wr_addr[5:2]][23:16] <= cmd.wr_data;
				2'd2:    blk_mem[cmd.wr_addr[5:2]][15:8]  <= cmd.wr_data;
				default: blk_mem[cmd.wr_addr[5:2]][7:0]   <= cmd.wr_data;
			endcase
		end
	end

	// message length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.init) begin
			len_q <= '0;
		end else if (cmd.len_inc) begin
			len_q <= len_q + 61'd1;
		end
	end

	// round logic
	logic [31:0] t1, t2, s0, s1, w_new, w_cur;
	always_comb begin
		w_cur = w_q[0];
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
			^ sha_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::ROUND_K[cmd.round_idx] + w_cur;
		t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
			^ sha_pkg::rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// schedule window and working variables
	always_ff @(posedge clk) begin
		if (cmd.blk_load) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk_mem[i];
			end
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::INIT_HASH[i];
		end else if (cmd.init) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::INIT_HASH[i];
		end else if (cmd.chain_add) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
		end
	end

	assign stat.len_max    = (len_q == sha_pkg::MAX_LEN);
	assign stat.length     = len_q;
	assign stat.chain_word = chain_q[cmd.rd_word];

endmodule

/* design/sha_ctrl.sv */
`timescale 1ns / 1ps
module sha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_cmd,
	input  logic [7:0]         in_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [37:0]        out_data,
	output sha_pkg::dp_cmd_t   dcmd,
	input  sha_pkg::dp_stat_t  dstat
);

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_LEN, S_EMIT, S_WAIT
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic        fin_q;     // compression is part of finish
	logic        second_q;  // length block pending after current
	logic [2:0]  idx_q;
	logic [63:0] bits_q;
	logic        ov_q;
	logic [37:0] od_q;

	assign in_ready  = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign out_data  = od_q;

	// datapath commands from state
	always_comb begin
		dcmd = '0;
		dcmd.rd_word   = idx_q;
		dcmd.round_idx = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					case (in_cmd)
						sha_pkg::CMD_APPEND: begin
							if (!done_q && !dstat.len_max) begin
								dcmd.wr_byte = 1'b1;
								dcmd.wr_addr = fill_q;
								dcmd.wr_data = in_byte;
								dcmd.len_inc = 1'b1;
							end
						end
						sha_pkg::CMD_FINISH: begin
							if (!done_q) begin
								dcmd.wr_byte = 1'b1;
								dcmd.wr_addr = fill_q;
								dcmd.wr_data = 8'h80;
							end
						end
						sha_pkg::CMD_RESTART: dcmd.init = 1'b1;
						default: ;
					endcase
				end
			end
			S_PAD: begin
				dcmd.wr_byte = 1'b1;
				dcmd.wr_addr = cnt_q;
				dcmd.wr_data = 8'h00;
			end
			S_LEN: begin
				dcmd.wr_byte = 1'b1;
				dcmd.wr_addr = cnt_q;
				dcmd.wr_data = bits_q[63:56];
			end
			S_LOAD:  dcmd.blk_load = 1'b1;
			S_ROUND: dcmd.round = 1'b1;
			S_ADD:   dcmd.chain_add = 1'b1;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			fin_q    <= 1'b0;
			second_q <= 1'b0;
			idx_q    <= '0;
			bits_q   <= '0;
			ov_q     <= 1'b0;
			od_q     <= '0;
		end else begin
			if (ov_q && out_ready && state_q != S_EMIT) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						case (in_cmd)
							sha_pkg::CMD_APPEND: begin
								if (done_q) begin
									ov_q <= 1'b1;
									od_q <= {1'b1, sha_pkg::ST_REJECTED, 35'd0};
								end else if (dstat.len_max) begin
									ov_q <= 1'b1;
									od_q <= {1'b1, sha_pkg::ST_OVERFLOW, 35'd0};
								end else begin
									fill_q <= fill_q + 6'd1;
									fin_q  <= 1'b0;
									od_q   <= {1'b1, sha_pkg::ST_OK, 35'd0};
									if (fill_q == 6'd63) begin
										state_q <= S_LOAD;
									end else begin
										ov_q <= 1'b1;
									end
								end
							end
							sha_pkg::CMD_FINISH: begin
								idx_q <= '0;
								if (done_q) begin
									state_q <= S_EMIT;
								end else begin
									bits_q   <= {dstat.length, 3'b000};
									fin_q    <= 1'b1;
									second_q <= (fill_q > 6'd55);
									cnt_q    <= fill_q + 6'd1;
									fill_q   <= fill_q + 6'd1;
									if (fill_q == 6'd63) begin
										state_q <= S_LOAD;
									end else if (fill_q == 6'd55) begin
										cnt_q   <= 6'd56;
										state_q <= S_LEN;
									end else begin
										state_q <= S_PAD;
									end
								end
							end
							sha_pkg::CMD_RESTART: begin
								fill_q <= '0;
								done_q <= 1'b0;
								ov_q   <= 1'b1;
								od_q   <= {1'b1, sha_pkg::ST_OK, 35'd0};
							end
							default: ;
						endcase
					end
				end
				S_PAD: begin
					// zero fill up to length field, or block end
					if (second_q && cnt_q == 6'd63) begin
						state_q <= S_LOAD;
					end else if (!second_q && cnt_q == 6'd55) begin
						cnt_q   <= 6'd56;
						state_q <= S_LEN;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_LEN: begin
					bits_q <= {bits_q[55:0], 8'h00};
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_ADD;
				end
				S_ADD: begin
					fill_q <= '0;
					if (!fin_q) begin
						ov_q    <= 1'b1;
						state_q <= S_WAIT;
					end else if (second_q) begin
						second_q <= 1'b0;
						cnt_q    <= '0;
						state_q  <= S_PAD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!ov_q || out_ready) begin
						ov_q  <= 1'b1;
						od_q  <= {idx_q == 3'd7, sha_pkg::ST_OK, idx_q, dstat.chain_word};
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!ov_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/sha256_stream_hasher_core.sv */
`timescale 1ns / 1ps
// channel  | dir | tdata bits (low first)                     | tuser
// s_axis   | in  | [1:0] cmd, [9:2] data_byte, rest zero       | -
// m_axis   | out | [31:0] digest_word, [34:32] word_index,     | -
//          |     | [36:35] status, rest zero                  | tlast = last
// append/restart: an append that fills a block adds a load, 64 rounds in the single
// shared round unit and a fold. finish: zero fill and length bytes one per cycle,
// one or two compressions, then 8 digest words. arst_n restores the initial hash.
// a stalled m_axis holds the sequencer; s_axis is not taken until the previous
// result word has left.
module sha256_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // cmd, data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word, word_index, status
	output logic        m_axis_tlast
);

	sha_pkg::dp_cmd_t  dcmd;
	sha_pkg::dp_stat_t dstat;
	logic [37:0]       od;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tdata[1:0]),
		.in_byte   (s_axis_tdata[9:2]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (od),
		.dcmd      (dcmd),
		.dstat     (dstat)
	);

	sha_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.stat   (dstat)
	);

	assign m_axis_tdata = {3'b000, od[36:0]};
	assign m_axis_tlast = od[37];

endmodule
